[hw/rtl/assert_macros.svh]
// Assertion macros shared by the oscillator bank RTL.
// Expects signals clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/wtosc_pkg.sv]
// Package for the wavetable oscillator bank: sizes, codes, voice types,
// and the elaboration-time sine table builder. No dependencies.
`timescale 1ns / 1ps

package wtosc_pkg;

  localparam int NUM_VOICES      = 8;
  localparam int WAVE_TABLE_SIZE = 1024;
  localparam int MAX_CHANNELS    = 8;

  localparam int PHASE_W  = $clog2(WAVE_TABLE_SIZE);
  localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CH_W     = 3;
  localparam int CNT_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int PROD_W   = SAMPLE_W + LEVEL_W + 1;
  localparam int TERM_W   = PROD_W - 15;
  localparam int ACC_W    = SAMPLE_W + VIDX_W + 1;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-32768);

  // commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // register map (word index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SELECTED_CHANNEL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPREAD_MODE      = 2'd2;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic [LEVEL_W-1:0] level;
    logic               active;
  } voice_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } cell_ctrl_t;

  typedef logic signed [SAMPLE_W-1:0] rom_t [WAVE_TABLE_SIZE];

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // full-cycle sine entry, quarter-wave Q30 polynomial, rounded to Q1.15
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(int unsigned k);
    longint unsigned a, q, r, m, x, x2, p, v, s;
    logic signed [SAMPLE_W-1:0] res;
    a  = 64'(k) * 64'd4;
    q  = a / WAVE_TABLE_SIZE;
    r  = a - q * WAVE_TABLE_SIZE;
    m  = q[0] ? (64'(WAVE_TABLE_SIZE) - r) : r;
    x  = (m * HALF_PI_Q30) / WAVE_TABLE_SIZE;
    x2 = (x * x) >> 30;
    p  = Q30_ONE;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd110;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd72;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd42;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd20;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd6;
    v  = (x * p) >> 30;
    s  = (v + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    res = s[SAMPLE_W-1:0];
    if (q >= 64'd2) res = -res;
    return res;
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < WAVE_TABLE_SIZE; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

endpackage

[hw/rtl/wtosc_voice_cell.sv]
// One voice cell of the rotating voice ring: holds phase, step, level, enable.
// Depends on wtosc_pkg.
`timescale 1ns / 1ps

module wtosc_voice_cell (
  input  logic                clk,
  input  logic                rst,
  input  wtosc_pkg::cell_ctrl_t ctrl,
  input  wtosc_pkg::voice_t   nbr_in,
  input  wtosc_pkg::voice_t   wr,
  output wtosc_pkg::voice_t   voice
);

  always_ff @(posedge clk) begin
    if (rst) begin
      voice <= '0;
    end else if (ctrl.shift) begin
      voice <= nbr_in;
    end else if (ctrl.load) begin
      voice.step   <= wr.step;
      voice.level  <= wr.level;
      voice.active <= wr.active;
      if (ctrl.clear) begin
        voice.phase <= '0;
      end
    end
  end

endmodule

[hw/rtl/wtosc_sine_rom.sv]
// Sine table, full cycle in Q1.15, registered read.
// Depends on wtosc_pkg (table built at elaboration).
`timescale 1ns / 1ps

module wtosc_sine_rom (
  input  logic                                       clk,
  input  logic [wtosc_pkg::PHASE_W-1:0]              addr,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0]      data
);

  localparam wtosc_pkg::rom_t ROM_TABLE = wtosc_pkg::build_rom();

  always_ff @(posedge clk) begin
    data <= ROM_TABLE[addr];
  end

endmodule

[hw/rtl/wtosc_mac.sv]
// Gain multiply and floor-scaled accumulate for one voice per cycle.
// Depends on wtosc_pkg; fed from wtosc_sine_rom.
`timescale 1ns / 1ps

module wtosc_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   issue,
  input  logic [wtosc_pkg::LEVEL_W-1:0]          level,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]  rom_data,
  input  logic                                   clear,
  output logic signed [wtosc_pkg::ACC_W-1:0]     acc,
  output logic                                   busy
);

  logic                                  va;
  logic                                  vb;
  logic [wtosc_pkg::LEVEL_W-1:0]         lvl_a;
  logic signed [wtosc_pkg::PROD_W-1:0]   prod;
  logic signed [wtosc_pkg::TERM_W-1:0]   term;

  // arithmetic shift gives floor division by 32768
  assign term = prod[wtosc_pkg::PROD_W-1:15];
  assign busy = va | vb;

  always_ff @(posedge clk) begin
    lvl_a <= level;
    prod  <= rom_data * $signed({1'b0, lvl_a});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= 1'b0;
      vb  <= 1'b0;
      acc <= '0;
    end else begin
      va <= issue;
      vb <= va;
      if (clear) begin
        acc <= '0;
      end else if (vb) begin
        acc <= acc + wtosc_pkg::ACC_W'(term);
      end
    end
  end

endmodule

[hw/rtl/wavetable_oscillator_bank_mixer_top.sv]
// Wavetable oscillator bank: ring of voice cells, sine ROM, one MAC, APB regs.
// Set-voice transaction: accepted while idle, no result. Tick: a mix is a slot for
// each voice, then the drain state and the emit state; a single-mode frame is one
// mix and then one emit per channel, a spread-mode frame one mix per channel, all
// on the one shared MAC walking the ring; a stalled output holds the emit state.
// Reset (rst, synchronous): voices cleared, count 2, channel 0, single mode.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wavetable_oscillator_bank_mixer_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // input transactions
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  command,
  input  logic [2:0]                            voice_index,
  input  logic [9:0]                            phase_step,
  input  logic [15:0]                           voice_gain,
  input  logic                                  voice_enable,
  input  logic                                  clear_phase,
  // output transactions
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            channel_index,
  output logic signed [15:0]                    sample,
  output logic                                  clipped,
  output logic                                  last_of_frame,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MIX   = 2'd1;  // one voice per cycle through the ring
  localparam logic [1:0] ST_DRAIN = 2'd2;  // wait for ROM/MAC pipeline
  localparam logic [1:0] ST_EMIT  = 2'd3;  // hand one sample to the output register

  // ---------------- registers ----------------
  logic [wtosc_pkg::CNT_W-1:0] channel_count;
  logic [wtosc_pkg::CH_W-1:0]  selected_channel;
  logic                        spread_mode;
  logic [wtosc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= wtosc_pkg::CNT_W'(2);
      selected_channel <= '0;
      spread_mode      <= 1'b0;
    end else if (reg_wr) begin
      case (reg_idx)
        wtosc_pkg::REG_CHANNEL_COUNT:    channel_count    <= pwdata[wtosc_pkg::CNT_W-1:0];
        wtosc_pkg::REG_SELECTED_CHANNEL: selected_channel <= pwdata[wtosc_pkg::CH_W-1:0];
        wtosc_pkg::REG_SPREAD_MODE:      spread_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wtosc_pkg::REG_CHANNEL_COUNT:    prdata = 32'(channel_count);
      wtosc_pkg::REG_SELECTED_CHANNEL: prdata = 32'(selected_channel);
      wtosc_pkg::REG_SPREAD_MODE:      prdata = 32'(spread_mode);
      default:                         prdata = '0;
    endcase
  end

  // effective count (zero acts as one, clamp to max) and selected channel
  logic [wtosc_pkg::CNT_W-1:0] count_eff;
  logic [wtosc_pkg::CH_W-1:0]  sel_eff;

  always_comb begin
    if (channel_count == '0) begin
      count_eff = wtosc_pkg::CNT_W'(1);
    end else if (channel_count > wtosc_pkg::CNT_W'(wtosc_pkg::MAX_CHANNELS)) begin
      count_eff = wtosc_pkg::CNT_W'(wtosc_pkg::MAX_CHANNELS);
    end else begin
      count_eff = channel_count;
    end
    sel_eff = ({1'b0, selected_channel} < count_eff) ? selected_channel : '0;
  end

  // ---------------- sequencer ----------------
  logic [1:0]                   state;
  logic [wtosc_pkg::VIDX_W-1:0] issue_cnt;
  logic [wtosc_pkg::CH_W-1:0]   ch_cnt;
  logic [wtosc_pkg::CNT_W-1:0]  ch_ext;
  logic                         in_acc;
  logic                         tick_acc;
  logic                         out_free;
  logic                         last;
  logic                         emit;
  logic                         mac_clear;
  logic                         mac_busy;
  logic signed [wtosc_pkg::ACC_W-1:0] acc;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && (command == wtosc_pkg::CMD_TICK);
  assign out_free = !out_valid || !out_stall;
  assign ch_ext   = {1'b0, ch_cnt};
  assign last     = (ch_ext == count_eff - wtosc_pkg::CNT_W'(1));
  assign emit     = (state == ST_EMIT) && out_free;
  // new mix: on a tick, and in spread mode before every further channel
  assign mac_clear = tick_acc || (emit && !last && spread_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      ch_cnt    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (tick_acc) begin
            state     <= ST_MIX;
            issue_cnt <= '0;
            ch_cnt    <= '0;
          end
        end
        ST_MIX: begin
          if (issue_cnt == wtosc_pkg::VIDX_W'(wtosc_pkg::NUM_VOICES - 1)) begin
            issue_cnt <= '0;
            state     <= ST_DRAIN;
          end else begin
            issue_cnt <= issue_cnt + wtosc_pkg::VIDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              ch_cnt <= ch_cnt + wtosc_pkg::CH_W'(1);
              if (spread_mode) begin
                state <= ST_MIX;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- voice ring ----------------
  // Cell 0 is the head. While mixing, the ring rotates one place per cycle and
  // the head's voice re-enters at the tail, its phase advanced if it is active;
  // after NUM_VOICES places every voice is back in its home cell.
  wtosc_pkg::voice_t cell_q [wtosc_pkg::NUM_VOICES];
  wtosc_pkg::voice_t head_adv;
  wtosc_pkg::voice_t wr_voice;

  always_comb begin
    head_adv = cell_q[0];
    if (cell_q[0].active) begin
      head_adv.phase = cell_q[0].phase + cell_q[0].step;  // wraps mod table size
    end
    wr_voice        = '0;
    wr_voice.step   = phase_step;
    wr_voice.level  = (voice_gain > wtosc_pkg::LEVEL_ONE) ? wtosc_pkg::LEVEL_ONE : voice_gain;
    wr_voice.active = voice_enable;
  end

  for (genvar i = 0; i < wtosc_pkg::NUM_VOICES; i++) begin : g_cell
    wtosc_pkg::cell_ctrl_t ctrl;
    wtosc_pkg::voice_t     nbr;

    assign ctrl.shift = (state == ST_MIX);
    assign ctrl.load  = in_acc && (command == wtosc_pkg::CMD_SET) &&
                        (voice_index == wtosc_pkg::VIDX_W'(i));
    assign ctrl.clear = clear_phase;

    if (i == wtosc_pkg::NUM_VOICES - 1) begin : g_tail
      assign nbr = head_adv;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    wtosc_voice_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .nbr_in (nbr),
      .wr     (wr_voice),
      .voice  (cell_q[i])
    );
  end

  // ---------------- ROM + MAC ----------------
  logic signed [wtosc_pkg::SAMPLE_W-1:0] rom_data;
  logic [wtosc_pkg::LEVEL_W-1:0]         issue_level;

  // disabled voice contributes nothing: zero its gain
  assign issue_level = cell_q[0].active ? cell_q[0].level : '0;

  wtosc_sine_rom u_rom (
    .clk  (clk),
    .addr (cell_q[0].phase),
    .data (rom_data)
  );

  wtosc_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .issue    (state == ST_MIX),
    .level    (issue_level),
    .rom_data (rom_data),
    .clear    (mac_clear),
    .acc      (acc),
    .busy     (mac_busy)
  );

  // ---------------- clip and output register ----------------
  logic signed [wtosc_pkg::SAMPLE_W-1:0] sat_val;
  logic                                  sat_flag;
  logic                                  use_mix;

  always_comb begin
    if (acc > wtosc_pkg::ACC_HI) begin
      sat_val  = 16'sh7FFF;
      sat_flag = 1'b1;
    end else if (acc < wtosc_pkg::ACC_LO) begin
      sat_val  = 16'sh8000;
      sat_flag = 1'b1;
    end else begin
      sat_val  = acc[wtosc_pkg::SAMPLE_W-1:0];
      sat_flag = 1'b0;
    end
    // single mode: only the selected channel carries the mix
    use_mix = spread_mode || (ch_cnt == sel_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel_index <= ch_cnt;
      sample        <= use_mix ? sat_val : '0;
      clipped       <= use_mix && sat_flag;
      last_of_frame <= last;
    end
  end

  // ---------------- checks ----------------
  `AST_HOLDS(a_idle_pipe_empty, state == ST_IDLE, !mac_busy)
  `AST_HOLDS(a_ring_home, state != ST_MIX, issue_cnt == '0)
  `AST_HOLDS(a_ch_in_range, state != ST_IDLE, ch_ext < count_eff)
  `AST_NEXT(a_last_to_idle, emit && last, state == ST_IDLE)

endmodule
